// ===== hw/rtl/snpb_pkg.sv =====
`timescale 1ns / 1ps

package snpb_pkg;

  localparam int unsigned TailBytes = 10;
  localparam int unsigned NumVarint = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] TAG_FIXED64 = 8'h09;
  localparam logic [7:0] TAG_NESTED = 8'h12;
  localparam logic [4:0] FIXED_SIZE = 5'd20;
  localparam logic [7:0] INNER_BASE = 8'd9;

  localparam logic [7:0] VARINT_TAG [NumVarint] = '{8'h10, 8'h18, 8'h20, 8'h28, 8'h30};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOMEM = 2'd2
  } snpb_status_e;

  typedef enum logic [1:0] {
    REG_BINDING_MAX = 2'd0,
    REG_AUTH_MAX    = 2'd1,
    REG_MAX_BYTES   = 2'd2
  } snpb_reg_e;

  typedef struct packed {
    logic                          single;
    snpb_status_e                  status;
    logic [4:0]                    total_length;
    logic [63:0]                   seq;
    logic [63:0]                   boot;
    logic [7:0]                    inner;
    logic [TailBytes-1:0][7:0]     tail;
  } snpb_cmd_t;

endpackage

// ===== hw/rtl/snpb_if.sv =====
`timescale 1ns / 1ps

interface snpb_in_if;
  logic        valid;
  logic        ready;
  logic        size_only;
  logic [63:0] snap_seq;
  logic [63:0] boot_id;
  logic [6:0]  binding_code;
  logic [6:0]  authorization_code;
  logic        encrypted;
  logic        bond_verified;
  logic        peer_known;
  logic [7:0]  capacity;

  modport source (
    output valid, size_only, snap_seq, boot_id, binding_code,
           authorization_code, encrypted, bond_verified, peer_known, capacity,
    input  ready
  );
  modport sink (
    input  valid, size_only, snap_seq, boot_id, binding_code,
           authorization_code, encrypted, bond_verified, peer_known, capacity,
    output ready
  );
endinterface

interface snpb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [4:0] total_length;
  logic       last;

  modport source (
    output valid, status, out_byte, byte_valid, total_length, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_byte, byte_valid, total_length, last,
    output ready
  );
endinterface

// ===== hw/rtl/snpb_front.sv =====
`timescale 1ns / 1ps

module snpb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [6:0]          cfg_wdata_i,
  snpb_in_if.sink             in_if,
  input  logic                q_full_i,
  output logic                push_o,
  output snpb_pkg::snpb_cmd_t cmd_o
);

  logic [6:0] binding_max_q;
  logic [6:0] auth_max_q;
  logic [5:0] max_bytes_q;

  logic [6:0] vals [snpb_pkg::NumVarint];
  logic [snpb_pkg::TailBytes-1:0][7:0] tail;
  logic [3:0] tail_pos;
  logic [2:0] pending;
  logic [4:0] size;
  logic       invalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binding_max_q <= 7'd2;
      auth_max_q    <= 7'd2;
      max_bytes_q   <= 6'd30;
    end else if (cfg_we_i) begin
      unique case (snpb_pkg::snpb_reg_e'(cfg_idx_i))
        snpb_pkg::REG_BINDING_MAX: binding_max_q <= cfg_wdata_i;
        snpb_pkg::REG_AUTH_MAX:    auth_max_q    <= cfg_wdata_i;
        snpb_pkg::REG_MAX_BYTES:   max_bytes_q   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !q_full_i;
  assign push_o      = in_if.valid && !q_full_i;

  assign vals[0] = in_if.binding_code;
  assign vals[1] = in_if.authorization_code;
  assign vals[2] = {6'd0, in_if.encrypted};
  assign vals[3] = {6'd0, in_if.bond_verified};
  assign vals[4] = {6'd0, in_if.peer_known};

  // pack the nonzero varint fields
  always_comb begin
    tail     = '0;
    tail_pos = '0;
    pending  = '0;
    for (int i = 0; i < int'(snpb_pkg::NumVarint); i++) begin
      if (vals[i] != 7'd0) begin
        tail[tail_pos]        = snpb_pkg::VARINT_TAG[i];
        tail[tail_pos + 4'd1] = {1'b0, vals[i]};
        tail_pos              = tail_pos + 4'd2;
        pending               = pending + 3'd1;
      end
    end
  end

  assign size    = snpb_pkg::FIXED_SIZE + {1'b0, pending, 1'b0};
  assign invalid = (in_if.snap_seq == 64'd0) || (in_if.boot_id == 64'd0) ||
                   (in_if.binding_code > binding_max_q) ||
                   (in_if.authorization_code > auth_max_q);

  always_comb begin
    cmd_o.seq   = in_if.snap_seq;
    cmd_o.boot  = in_if.boot_id;
    cmd_o.inner = snpb_pkg::INNER_BASE + {4'd0, pending, 1'b0};
    cmd_o.tail  = tail;
    if (invalid) begin
      cmd_o.single       = 1'b1;
      cmd_o.status       = snpb_pkg::ST_INVAL;
      cmd_o.total_length = '0;
    end else if ({1'b0, size} > max_bytes_q) begin
      cmd_o.single       = 1'b1;
      cmd_o.status       = snpb_pkg::ST_NOMEM;
      cmd_o.total_length = '0;
    end else if (in_if.size_only) begin
      cmd_o.single       = 1'b1;
      cmd_o.status       = snpb_pkg::ST_OK;
      cmd_o.total_length = size;
    end else if (in_if.capacity < {3'd0, size}) begin
      cmd_o.single       = 1'b1;
      cmd_o.status       = snpb_pkg::ST_NOMEM;
      cmd_o.total_length = '0;
    end else begin
      cmd_o.single       = 1'b0;
      cmd_o.status       = snpb_pkg::ST_OK;
      cmd_o.total_length = size;
    end
  end

endmodule

// ===== hw/rtl/snpb_queue.sv =====
`timescale 1ns / 1ps

module snpb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  snpb_pkg::snpb_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output snpb_pkg::snpb_cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(snpb_pkg::QueueDepth);

  snpb_pkg::snpb_cmd_t mem_q [snpb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(snpb_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(snpb_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(snpb_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/snpb_back.sv =====
`timescale 1ns / 1ps

module snpb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  snpb_pkg::snpb_cmd_t cmd_i,
  output logic                pop_o,
  snpb_out_if.source          out_if
);

  logic [4:0] k_q, k_d;
  logic       ovalid_q, ovalid_d;
  logic [1:0] status_q;
  logic [7:0] byte_q, byte_d;
  logic       bvalid_q;
  logic [4:0] len_q;
  logic       last_q;

  logic load;
  logic is_last;
  logic [2:0] seq_idx;
  logic [2:0] boot_idx;
  logic [3:0] tail_idx;

  assign load    = q_valid_i && (!ovalid_q || out_if.ready);
  assign is_last = cmd_i.single || (k_q == cmd_i.total_length - 5'd1);
  assign pop_o   = load && is_last;

  assign seq_idx  = 3'(k_q - 5'd1);
  assign boot_idx = 3'(k_q - 5'd12);
  assign tail_idx = 4'(k_q - 5'd20);

  // byte at position k of the encoding
  always_comb begin
    case (k_q) inside
      5'd0, 5'd11:   byte_d = snpb_pkg::TAG_FIXED64;
      [5'd1:5'd8]:   byte_d = cmd_i.seq[8*seq_idx +: 8];
      5'd9:          byte_d = snpb_pkg::TAG_NESTED;
      5'd10:         byte_d = cmd_i.inner;
      [5'd12:5'd19]: byte_d = cmd_i.boot[8*boot_idx +: 8];
      default:       byte_d = cmd_i.tail[tail_idx];
    endcase
  end

  always_comb begin
    k_d      = k_q;
    ovalid_d = ovalid_q;
    if (!ovalid_q || out_if.ready) begin
      ovalid_d = q_valid_i;
    end
    if (load) begin
      k_d = is_last ? 5'd0 : k_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      k_q      <= k_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= cmd_i.status;
      len_q    <= cmd_i.total_length;
      last_q   <= is_last;
      bvalid_q <= !cmd_i.single;
      byte_q   <= cmd_i.single ? 8'd0 : byte_d;
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.status       = status_q;
  assign out_if.out_byte     = byte_q;
  assign out_if.byte_valid   = bvalid_q;
  assign out_if.total_length = len_q;
  assign out_if.last         = last_q;

endmodule

// ===== hw/rtl/snapshot_protobuf_encoder_core.sv =====
`timescale 1ns / 1ps

// Link snapshot protobuf encoder. Each input transaction is one snapshot; the
// block answers with one output transaction per encoded byte (20 to 30, last
// set on the final byte), or with a single transaction carrying only the
// status and, for a size-only query, the length. Output runs at one
// transaction per cycle from the byte emitter while the sink keeps ready
// high. A two-entry command queue sits between the checking front end and
// the emitter, so new snapshots are taken while earlier bytes still drain.
// Registers (index 0 binding max, 1 authorization max, 2 size limit) are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write
// them only while the block is idle, as the block itself does not enforce it.

module snapshot_protobuf_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_wdata_i,
  snpb_in_if.sink    in_if,
  snpb_out_if.source out_if
);

  snpb_pkg::snpb_cmd_t push_cmd;
  snpb_pkg::snpb_cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  snpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  snpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  snpb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule

// ===== hw/rtl/snpb_checker.sv =====
`timescale 1ns / 1ps

module snpb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_status_i,
  input logic [7:0] out_byte_i,
  input logic       out_byte_valid_i,
  input logic [4:0] out_total_length_i,
  input logic       out_last_i
);

  // stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(out_last_i) && $stable(out_status_i))
    else $error("output changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_byte_valid_i |->
      out_status_i == snpb_pkg::ST_OK && out_total_length_i >= 5'd20 &&
      out_total_length_i <= 5'd30)
    else $error("data byte with bad status or length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_valid_i |-> out_last_i && out_byte_i == 8'd0)
    else $error("status-only transaction not final");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != snpb_pkg::ST_OK |->
      out_total_length_i == 5'd0 && !out_byte_valid_i)
    else $error("error transaction carries length");

endmodule

bind snapshot_protobuf_encoder_core snpb_checker u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_if.valid),
  .out_ready_i        (out_if.ready),
  .out_status_i       (out_if.status),
  .out_byte_i         (out_if.out_byte),
  .out_byte_valid_i   (out_if.byte_valid),
  .out_total_length_i (out_if.total_length),
  .out_last_i         (out_if.last)
);

// ===== tb/snapshot_protobuf_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module snapshot_protobuf_encoder_core_tb;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 2000;

  typedef struct packed {
    logic        size_only;
    logic [63:0] snap_seq;
    logic [63:0] boot_id;
    logic [6:0]  binding_code;
    logic [6:0]  authorization_code;
    logic        encrypted;
    logic        bond_verified;
    logic        peer_known;
    logic [7:0]  capacity;
  } snap_item_t;

  typedef struct packed {
    snpb_pkg::snpb_status_e status;
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic [4:0]             total_length;
    logic                   last;
  } snap_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [6:0] cfg_wdata_i;

  snpb_in_if  in_ch ();
  snpb_out_if out_ch ();

  snapshot_protobuf_encoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  snap_item_t   pending_snaps [$];
  snap_result_t expected_bytes [$];
  snap_item_t   offered = '0;
  snap_item_t   next_snap;

  logic [6:0] bind_limit;
  logic [6:0] auth_limit;
  logic [5:0] size_limit;

  logic        no_gap;
  int unsigned snaps_taken = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  assign in_ch.size_only          = offered.size_only;
  assign in_ch.snap_seq           = offered.snap_seq;
  assign in_ch.boot_id            = offered.boot_id;
  assign in_ch.binding_code       = offered.binding_code;
  assign in_ch.authorization_code = offered.authorization_code;
  assign in_ch.encrypted          = offered.encrypted;
  assign in_ch.bond_verified      = offered.bond_verified;
  assign in_ch.peer_known         = offered.peer_known;
  assign in_ch.capacity           = offered.capacity;

  always #1 clk_i = ~clk_i;

  function automatic snap_result_t status_only(snpb_pkg::snpb_status_e st,
                                               logic [4:0] len);
    snap_result_t r;
    r.status       = st;
    r.out_byte     = 8'h00;
    r.byte_valid   = 1'b0;
    r.total_length = len;
    r.last         = 1'b1;
    return r;
  endfunction

  task automatic encode_snapshot(input snap_item_t s);
    logic [7:0]   stream [$];
    int unsigned  fields;
    logic [4:0]   size;
    logic [7:0]   inner;
    snap_result_t r;
    int           k;
    fields = 0;
    if (s.snap_seq == '0 || s.boot_id == '0 || s.binding_code > bind_limit ||
        s.authorization_code > auth_limit) begin
      expected_bytes.push_back(status_only(snpb_pkg::ST_INVAL, 5'd0));
      return;
    end
    if (s.binding_code != '0) fields++;
    if (s.authorization_code != '0) fields++;
    if (s.encrypted) fields++;
    if (s.bond_verified) fields++;
    if (s.peer_known) fields++;
    inner = snpb_pkg::INNER_BASE + 8'(2 * fields);
    size  = snpb_pkg::FIXED_SIZE + 5'(2 * fields);
    if ({1'b0, size} > size_limit) begin
      expected_bytes.push_back(status_only(snpb_pkg::ST_NOMEM, 5'd0));
    end else if (s.size_only) begin
      expected_bytes.push_back(status_only(snpb_pkg::ST_OK, size));
    end else if (s.capacity < {3'b000, size}) begin
      expected_bytes.push_back(status_only(snpb_pkg::ST_NOMEM, 5'd0));
    end else begin
      stream.push_back(snpb_pkg::TAG_FIXED64);
      for (k = 0; k < 8; k++) stream.push_back(s.snap_seq[8*k +: 8]);
      stream.push_back(snpb_pkg::TAG_NESTED);
      stream.push_back(inner);
      stream.push_back(snpb_pkg::TAG_FIXED64);
      for (k = 0; k < 8; k++) stream.push_back(s.boot_id[8*k +: 8]);
      if (s.binding_code != '0) begin
        stream.push_back(snpb_pkg::VARINT_TAG[0]);
        stream.push_back({1'b0, s.binding_code});
      end
      if (s.authorization_code != '0) begin
        stream.push_back(snpb_pkg::VARINT_TAG[1]);
        stream.push_back({1'b0, s.authorization_code});
      end
      if (s.encrypted) begin
        stream.push_back(snpb_pkg::VARINT_TAG[2]);
        stream.push_back(8'h01);
      end
      if (s.bond_verified) begin
        stream.push_back(snpb_pkg::VARINT_TAG[3]);
        stream.push_back(8'h01);
      end
      if (s.peer_known) begin
        stream.push_back(snpb_pkg::VARINT_TAG[4]);
        stream.push_back(8'h01);
      end
      for (k = 0; k < stream.size(); k++) begin
        r.status       = snpb_pkg::ST_OK;
        r.out_byte     = stream[k];
        r.byte_valid   = 1'b1;
        r.total_length = size;
        r.last         = (k == stream.size() - 1);
        expected_bytes.push_back(r);
      end
    end
  endtask

  function automatic snap_item_t make_snap(logic so, logic [63:0] seq, logic [63:0] boot,
                                           logic [6:0] bcode, logic [6:0] acode, logic enc,
                                           logic bond, logic ident, logic [7:0] cap);
    snap_item_t s;
    s.size_only          = so;
    s.snap_seq           = seq;
    s.boot_id            = boot;
    s.binding_code       = bcode;
    s.authorization_code = acode;
    s.encrypted          = enc;
    s.bond_verified      = bond;
    s.peer_known         = ident;
    s.capacity           = cap;
    return s;
  endfunction

  function automatic snap_item_t random_snapshot();
    snap_item_t  s;
    int unsigned need;
    s.snap_seq           = {$urandom, $urandom};
    s.boot_id            = {$urandom, $urandom};
    s.encrypted          = 1'($urandom_range(0, 1));
    s.bond_verified      = 1'($urandom_range(0, 1));
    s.peer_known         = 1'($urandom_range(0, 1));
    s.size_only          = ($urandom_range(0, 99) < 15);
    if ($urandom_range(0, 99) < 80) begin
      if (s.snap_seq == '0) s.snap_seq = 64'd1;
      if (s.boot_id == '0) s.boot_id = 64'd1;
      s.binding_code       = 7'($urandom_range(0, 32'(bind_limit)));
      s.authorization_code = 7'($urandom_range(0, 32'(auth_limit)));
      need = 32'(snpb_pkg::FIXED_SIZE);
      if (s.binding_code != '0) need += 2;
      if (s.authorization_code != '0) need += 2;
      if (s.encrypted) need += 2;
      if (s.bond_verified) need += 2;
      if (s.peer_known) need += 2;
      if ($urandom_range(0, 7) == 0) s.capacity = 8'(need - $urandom_range(0, 2));
      else s.capacity = 8'($urandom_range(need, 255));
    end else begin
      s.binding_code       = 7'($urandom_range(0, 127));
      s.authorization_code = 7'($urandom_range(0, 127));
      s.capacity           = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: s.snap_seq = '0;
        1: s.boot_id = '0;
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    snap_result_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("unexpected result, byte", 64'(out_ch.out_byte), 64'd0);
    end else begin
      want = expected_bytes.pop_front();
      if (out_ch.status !== want.status)
        report_mismatch("status", 64'(out_ch.status), 64'(want.status));
      if (out_ch.out_byte !== want.out_byte)
        report_mismatch("out_byte", 64'(out_ch.out_byte), 64'(want.out_byte));
      if (out_ch.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", 64'(out_ch.byte_valid), 64'(want.byte_valid));
      if (out_ch.total_length !== want.total_length)
        report_mismatch("total_length", 64'(out_ch.total_length),
                        64'(want.total_length));
      if (out_ch.last !== want.last)
        report_mismatch("last", 64'(out_ch.last), 64'(want.last));
    end
    results_seen++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      snpb_pkg::REG_BINDING_MAX: bind_limit = data;
      snpb_pkg::REG_AUTH_MAX:    auth_limit = data;
      snpb_pkg::REG_MAX_BYTES:   size_limit = data[5:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [6:0] bmax, input logic [6:0] amax,
                            input logic [6:0] maxb);
    write_reg(snpb_pkg::REG_BINDING_MAX, bmax);
    write_reg(snpb_pkg::REG_AUTH_MAX, amax);
    write_reg(snpb_pkg::REG_MAX_BYTES, maxb);
    @(negedge clk_i);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) pending_snaps.push_back(random_snapshot());
  endtask

  task automatic wait_drained();
    while (pending_snaps.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_snapshot(offered);
        snaps_taken <= snaps_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_snaps.size() != 0 && (no_gap || $urandom_range(0, 99) >= 25)) begin
          next_snap = pending_snaps.pop_front();
          offered     <= next_snap;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with long hold-offs to back up the command queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if ((holds_done == 0 && snaps_taken >= 50) ||
                   (holds_done == 1 && snaps_taken >= 130)) begin
        hold_left    <= HoldCycles;
        holds_done   <= holds_done + 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gap || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = snpb_pkg::REG_BINDING_MAX;
    cfg_wdata_i  = '0;
    bind_limit   = 7'd2;
    auth_limit   = 7'd2;
    size_limit   = 6'd30;
    no_gap       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits
    pending_snaps.push_back(make_snap(1'b0, 64'd1, 64'd1, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, '1, '1, 7'd2, 7'd2, 1'b1, 1'b1, 1'b1,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd0, 64'd5, 7'd1, 7'd1, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd5, 64'd0, 7'd1, 7'd1, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd7, 64'd9, 7'd3, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd7, 64'd9, 7'd0, 7'd3, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd7, 64'd9, 7'd127, 7'd127, 1'b1, 1'b1,
                                      1'b1, 8'd0));
    pending_snaps.push_back(make_snap(1'b1, '1, '1, 7'd2, 7'd2, 1'b1, 1'b1, 1'b1, 8'd0));
    pending_snaps.push_back(make_snap(1'b1, 64'd0, 64'd0, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210,
                                      7'd2, 7'd2, 1'b1, 1'b1, 1'b1, 8'd29));
    pending_snaps.push_back(make_snap(1'b0, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5,
                                      7'd1, 7'd0, 1'b0, 1'b0, 1'b0, 8'd22));
    pending_snaps.push_back(make_snap(1'b0, 64'd3, 64'd4, 7'd0, 7'd1, 1'b1, 1'b0, 1'b0,
                                      8'd23));
    pending_snaps.push_back(make_snap(1'b0, 64'h8000000000000000, 64'h0123456789abcdef,
                                      7'd0, 7'd0, 1'b0, 1'b1, 1'b0, 8'd128));
    pending_snaps.push_back(make_snap(1'b0, 64'h0123456789abcdef, 64'h8000000000000001,
                                      7'd0, 7'd2, 1'b0, 1'b0, 1'b1, 8'd255));
    pending_snaps.push_back(make_snap(1'b1, 64'd1, 64'd1, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd0));
    queue_random(20);
    wait_drained();

    // widest limits, size limit written with its spare bit set
    set_limits(7'd127, 7'd127, 7'h7f);
    write_reg(RegSpare, 7'h55);
    @(negedge clk_i);
    pending_snaps.push_back(make_snap(1'b0, '1, '1, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd5, 64'd5, 7'd64, 7'd1, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd5, 64'd5, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd20));
    queue_random(50);
    wait_drained();

    // only the bare snapshot fits
    set_limits(7'd0, 7'd0, 7'd20);
    queue_random(25);
    wait_drained();

    // size limit in the middle of the range
    set_limits(7'd5, 7'd9, 7'd25);
    pending_snaps.push_back(make_snap(1'b1, 64'd9, 64'd9, 7'd2, 7'd2, 1'b1, 1'b0, 1'b0,
                                      8'd0));
    pending_snaps.push_back(make_snap(1'b0, 64'd9, 64'd9, 7'd2, 7'd0, 1'b1, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd9, 64'd9, 7'd6, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    queue_random(40);
    wait_drained();

    // zero size limit
    set_limits(7'd127, 7'd127, 7'd0);
    pending_snaps.push_back(make_snap(1'b1, 64'd1, 64'd1, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd0, 64'd1, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    pending_snaps.push_back(make_snap(1'b0, 64'd1, 64'd1, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0,
                                      8'd255));
    queue_random(15);
    wait_drained();

    // back-to-back stretch
    set_limits(7'd127, 7'd127, 7'd30);
    no_gap = 1'b1;
    queue_random(60);
    wait_drained();
    no_gap = 1'b0;

    set_limits(7'd64, 7'd3, 7'd28);
    queue_random(25);
    wait_drained();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
